>>> rtl/core/ptp_pkg.sv
`default_nettype none

package ptp_pkg;

  localparam int CoordW      = 24;
  localparam int TagW        = 18;
  localparam int PixW        = 16;
  localparam int RotW        = 16;
  localparam int ProdW       = RotW + CoordW;
  localparam int C14W        = 42;
  localparam int C8W         = 36;
  localparam int SplitW      = 18;
  localparam int FocW        = 24;
  localparam int NumW        = 64;
  localparam int DenW        = 44;
  localparam int RemW        = 63;
  localparam int QW          = PixW;
  localparam int CfgW        = 64;
  localparam int CfgIdxW     = 3;
  localparam int DefMidDepth = 4;
  localparam int DefOutDepth = 4;
  localparam int DefTagBits  = 18;

  // 1 m in Q.14 millimetres
  localparam logic signed [C14W-1:0] DepthMinQ14 = 42'sd16384000;

  localparam logic [CfgW-1:0] RotXReset = 64'd16384;
  localparam logic [CfgW-1:0] RotYReset = 64'd1073741824;
  localparam logic [CfgW-1:0] RotZReset = 64'd70368744177664;
  localparam logic [47:0]     DistReset = 48'd1677721600000;

  typedef enum logic [1:0] {
    REJ_NONE  = 2'd0,
    REJ_DEPTH = 2'd1,
    REJ_IMAGE = 2'd2,
    REJ_RANGE = 2'd3
  } reject_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROT_X     = 3'd0,
    CFG_ROT_Y     = 3'd1,
    CFG_ROT_Z     = 3'd2,
    CFG_FOCAL     = 3'd3,
    CFG_PRINCIPAL = 3'd4,
    CFG_IMAGE     = 3'd5,
    CFG_DIST      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic [TagW-1:0]          point_tag;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_col;
    logic [PixW-1:0] pixel_row;
    logic            hit;
    logic [1:0]      reject_code;
    logic [TagW-1:0] tag_out;
  } out_item_t;

  typedef struct packed {
    logic [2:0][CfgW-1:0] rot;
    logic [47:0]          focal;
    logic [47:0]          principal;
    logic [31:0]          img;
    logic [47:0]          dist_lim;
  } cfg_t;

  // Front-to-back item: projection numerators, common denominator, early flags
  typedef struct packed {
    logic signed [NumW-1:0] num_x;
    logic signed [NumW-1:0] num_y;
    logic [DenW-1:0]        den;
    logic                   depth_bad;
    logic                   dist_bad;
    logic [TagW-1:0]        tag;
  } mid_item_t;

endpackage

`default_nettype wire

>>> rtl/core/ptp_fifo.sv
`default_nettype none

module ptp_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int PtrW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW:0]    wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    ptr_diff;

  assign ptr_diff = wr_ptr_q ^ rd_ptr_q;
  assign full_o   = (ptr_diff == {1'b1, {PtrW{1'b0}}});
  assign empty_o  = (wr_ptr_q == rd_ptr_q);
  assign data_o   = mem_q[rd_ptr_q[PtrW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i && !full_o) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i && !empty_o) rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_ptr_q[PtrW-1:0]] <= data_i;
  end

endmodule

`default_nettype wire

>>> rtl/core/ptp_front.sv
`default_nettype none

module ptp_front import ptp_pkg::*; #(
  parameter int POINT_TAG_BITS = DefTagBits
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      in_valid_i,
  input  wire in_item_t  in_item_i,
  output logic           in_ready_o,
  output logic           mid_push_o,
  output mid_item_t      mid_item_o,
  input  wire logic      mid_full_i
);

  localparam int KeepW = (POINT_TAG_BITS < TagW) ? POINT_TAG_BITS : TagW;
  localparam logic [TagW-1:0] TagMask = TagW'((64'd1 << KeepW) - 64'd1);

  function automatic logic [C8W-1:0] mag(input logic signed [C8W-1:0] v);
    logic [C8W-1:0] r;
    r = v[C8W-1] ? C8W'(-v) : C8W'(v);
    return r;
  endfunction

  logic en;
  logic f1_v_q, f2_v_q, f3_v_q;

  // stage 1: rotation products
  logic signed [CoordW-1:0] pt [3];
  logic signed [ProdW-1:0]  f1_prod_d [3][3];
  logic signed [ProdW-1:0]  f1_prod_q [3][3];
  logic signed [RotW-1:0]   f1_trans_q [3];
  logic [TagW-1:0]          f1_tag_q;

  // stage 2: camera coordinates in Q.14 mm
  logic signed [C14W-1:0] f2_c14_d [3];
  logic signed [C14W-1:0] f2_c14_q [3];
  logic [TagW-1:0]        f2_tag_q;

  // stage 3: partial products of the projection and squared distances
  logic signed [C8W-1:0]  c8 [3];
  logic [C8W-1:0]         amag [3];
  logic [FocW-1:0]        foc [2];
  logic [FocW:0]          ctr [2];
  logic [SplitW-1:0]      lo [2];
  logic signed [C8W-SplitW-1:0] hi [2];
  logic [SplitW-1:0]      zlo;
  logic signed [C8W-SplitW-1:0] zhi;
  logic [FocW+SplitW-1:0]         pl_d [2], pl_q [2];
  logic signed [FocW+SplitW:0]    ph_d [2], ph_q [2];
  logic [FocW+SplitW:0]           cl_d [2], cl_q [2];
  logic signed [FocW+SplitW+1:0]  ch_d [2], ch_q [2];
  logic [63:0]            sq_d [3], sq_q [3];
  logic                   huge_d, huge_q;
  logic                   depth_bad_q;
  logic [DenW-1:0]        den_q;
  logic [TagW-1:0]        f3_tag_q;

  logic [31:0] dmin_s, dmax_s;
  logic [63:0] minsq_q, maxsq_q;
  logic [65:0] d2;

  assign en         = !(f3_v_q && mid_full_i);
  assign in_ready_o = en;
  assign mid_push_o = f3_v_q && !mid_full_i;

  assign pt[0] = in_item_i.point_x;
  assign pt[1] = in_item_i.point_y;
  assign pt[2] = in_item_i.point_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        f1_prod_d[i][j] = $signed(cfg_i.rot[i][RotW*j +: RotW]) * pt[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f2_c14_d[i] = C14W'(f1_prod_q[i][0]) + C14W'(f1_prod_q[i][1])
                  + C14W'(f1_prod_q[i][2])
                  + C14W'($signed({f1_trans_q[i], 14'b0}));
    end
  end

  assign foc[0] = cfg_i.focal[23:0];
  assign foc[1] = cfg_i.focal[47:24];
  // +0.5 px folded into the principal point gives round half up
  assign ctr[0] = {1'b0, cfg_i.principal[23:0]} + 25'd128;
  assign ctr[1] = {1'b0, cfg_i.principal[47:24]} + 25'd128;

  always_comb begin
    huge_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      c8[i]   = C8W'(f2_c14_q[i] >>> 6);
      amag[i] = mag(c8[i]);
      huge_d  = huge_d | (amag[i][C8W-1:32] != '0);
      sq_d[i] = amag[i][31:0] * amag[i][31:0];
    end
    zlo = c8[2][SplitW-1:0];
    zhi = c8[2][C8W-1:SplitW];
    for (int a = 0; a < 2; a++) begin
      lo[a]   = c8[a][SplitW-1:0];
      hi[a]   = c8[a][C8W-1:SplitW];
      pl_d[a] = foc[a] * lo[a];
      ph_d[a] = $signed({1'b0, foc[a]}) * hi[a];
      cl_d[a] = ctr[a] * zlo;
      ch_d[a] = $signed({1'b0, ctr[a]}) * zhi;
    end
  end

  assign dmin_s = {cfg_i.dist_lim[23:0], 8'b0};
  assign dmax_s = {cfg_i.dist_lim[47:24], 8'b0};

  always_ff @(posedge clk_i) begin
    minsq_q <= dmin_s * dmin_s;
    maxsq_q <= dmax_s * dmax_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= in_valid_i;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          f1_prod_q[i][j] <= f1_prod_d[i][j];
        end
        f1_trans_q[i] <= $signed(cfg_i.rot[i][63:48]);
        f2_c14_q[i]   <= f2_c14_d[i];
        sq_q[i]       <= sq_d[i];
      end
      for (int a = 0; a < 2; a++) begin
        pl_q[a] <= pl_d[a];
        ph_q[a] <= ph_d[a];
        cl_q[a] <= cl_d[a];
        ch_q[a] <= ch_d[a];
      end
      f1_tag_q    <= in_item_i.point_tag & TagMask;
      f2_tag_q    <= f1_tag_q;
      f3_tag_q    <= f2_tag_q;
      huge_q      <= huge_d;
      depth_bad_q <= (f2_c14_q[2] < DepthMinQ14);
      den_q       <= {c8[2][C8W-1:0], 8'b0};
    end
  end

  // recombine the split products; saturation of the distance sum is not
  // needed since any sum past 2^64 already exceeds the largest limit
  assign d2 = 66'(sq_q[0]) + 66'(sq_q[1]) + 66'(sq_q[2]);

  always_comb begin
    mid_item_o.num_x = NumW'($signed({1'b0, pl_q[0]})) + (NumW'(ph_q[0]) <<< SplitW)
                     + NumW'($signed({1'b0, cl_q[0]})) + (NumW'(ch_q[0]) <<< SplitW);
    mid_item_o.num_y = NumW'($signed({1'b0, pl_q[1]})) + (NumW'(ph_q[1]) <<< SplitW)
                     + NumW'($signed({1'b0, cl_q[1]})) + (NumW'(ch_q[1]) <<< SplitW);
    mid_item_o.den       = den_q;
    mid_item_o.depth_bad = depth_bad_q;
    mid_item_o.dist_bad  = huge_q || (d2 < {2'b0, minsq_q}) || (d2 > {2'b0, maxsq_q});
    mid_item_o.tag       = f3_tag_q;
  end

endmodule

`default_nettype wire

>>> rtl/core/ptp_back.sv
`default_nettype none

module ptp_back import ptp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      mid_empty_i,
  input  wire mid_item_t mid_item_i,
  output logic           mid_pop_o,
  output logic           out_push_o,
  output out_item_t      out_item_o,
  input  wire logic      out_full_i
);

  typedef struct packed {
    logic [RemW-1:0] rem_x;
    logic [RemW-1:0] rem_y;
    logic [QW-1:0]   q_x;
    logic [QW-1:0]   q_y;
    logic            oor_x;
    logic            oor_y;
    logic [DenW-1:0] den;
    logic            depth_bad;
    logic            dist_bad;
    logic [TagW-1:0] tag;
  } div_t;

  logic      en;
  logic      b0_v_q;
  mid_item_t b0_q;
  logic      st_v_q [QW];
  div_t      st_q [QW];
  div_t      st_in [QW];
  div_t      st_d [QW];
  div_t      last;
  logic [RemW-1:0] lim;
  logic      img_bad;
  reject_e   code;

  assign en        = !(st_v_q[QW-1] && out_full_i);
  assign mid_pop_o = en && !mid_empty_i;

  // quotient beyond 16 bits or negative can never land in the image
  assign lim = RemW'({b0_q.den, {QW{1'b0}}});

  always_comb begin
    st_in[0].rem_x     = b0_q.num_x[RemW-1:0];
    st_in[0].rem_y     = b0_q.num_y[RemW-1:0];
    st_in[0].q_x       = '0;
    st_in[0].q_y       = '0;
    st_in[0].oor_x     = b0_q.num_x[NumW-1] || (b0_q.num_x[RemW-1:0] >= lim);
    st_in[0].oor_y     = b0_q.num_y[NumW-1] || (b0_q.num_y[RemW-1:0] >= lim);
    st_in[0].den       = b0_q.den;
    st_in[0].depth_bad = b0_q.depth_bad;
    st_in[0].dist_bad  = b0_q.dist_bad;
    st_in[0].tag       = b0_q.tag;
  end

  // one restoring quotient bit per stage, MSB first
  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int K = QW - 1 - s;
    logic [RemW-1:0] sh;
    if (s > 0) begin : g_link
      assign st_in[s] = st_q[s-1];
    end
    assign sh = RemW'(st_in[s].den) << K;
    always_comb begin
      st_d[s] = st_in[s];
      if (st_in[s].rem_x >= sh) begin
        st_d[s].rem_x  = st_in[s].rem_x - sh;
        st_d[s].q_x[K] = 1'b1;
      end
      if (st_in[s].rem_y >= sh) begin
        st_d[s].rem_y  = st_in[s].rem_y - sh;
        st_d[s].q_y[K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q <= 1'b0;
      for (int s = 0; s < QW; s++) st_v_q[s] <= 1'b0;
    end else if (en) begin
      b0_v_q    <= !mid_empty_i;
      st_v_q[0] <= b0_v_q;
      for (int s = 1; s < QW; s++) st_v_q[s] <= st_v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_q <= mid_item_i;
      for (int s = 0; s < QW; s++) st_q[s] <= st_d[s];
    end
  end

  assign last    = st_q[QW-1];
  assign img_bad = last.oor_x || last.oor_y
                || (last.q_x >= cfg_i.img[15:0]) || (last.q_y >= cfg_i.img[31:16]);

  always_comb begin
    priority if (last.depth_bad) code = REJ_DEPTH;
    else if (img_bad)            code = REJ_IMAGE;
    else if (last.dist_bad)      code = REJ_RANGE;
    else                         code = REJ_NONE;
  end

  assign out_push_o             = st_v_q[QW-1] && !out_full_i;
  assign out_item_o.hit         = (code == REJ_NONE);
  assign out_item_o.pixel_col   = (code == REJ_NONE) ? last.q_x : '0;
  assign out_item_o.pixel_row   = (code == REJ_NONE) ? last.q_y : '0;
  assign out_item_o.reject_code = code;
  assign out_item_o.tag_out     = last.tag;

endmodule

`default_nettype wire

>>> rtl/core/point_to_pixel_projection_core.sv
`default_nettype none

// channel   direction  handshake             payload
// input     in         push / full           in_item_i  (in_item_t)
// result    out        empty / pop           out_item_o (out_item_t)
// config    in         cfg_we_i, cfg_idx_i   cfg_wdata_i (64 bit)
//
// One item per cycle sustained while no full queue stalls it; an accepted item passes
// three front stages, one stage in each queue, one back input stage and the
// 16-stage quotient pipeline on its way to the result ports.
// A queue between front and back lets each stall alone; the front stalls only
// when that queue is full, the back only when the result queue is full.
// Reset (async, low) empties both queues and loads the identity pose and
// 0..100 m distance limits.

module point_to_pixel_projection_core import ptp_pkg::*; #(
  parameter int POINT_TAG_BITS = DefTagBits,
  parameter int MID_DEPTH      = DefMidDepth,
  parameter int OUT_DEPTH      = DefOutDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire in_item_t           in_item_i,
  output logic                    empty,
  input  wire logic               pop,
  output out_item_t               out_item_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i
);

  cfg_t      cfg_q;
  logic      in_ready;
  logic      mid_push, mid_full, mid_pop, mid_empty;
  mid_item_t mid_wdata, mid_rdata;
  logic      out_push, out_full;
  out_item_t out_wdata;

  assign full = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot[0]     <= RotXReset;
      cfg_q.rot[1]     <= RotYReset;
      cfg_q.rot[2]     <= RotZReset;
      cfg_q.focal      <= '0;
      cfg_q.principal  <= '0;
      cfg_q.img        <= '0;
      cfg_q.dist_lim   <= DistReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROT_X:     cfg_q.rot[0]    <= cfg_wdata_i;
        CFG_ROT_Y:     cfg_q.rot[1]    <= cfg_wdata_i;
        CFG_ROT_Z:     cfg_q.rot[2]    <= cfg_wdata_i;
        CFG_FOCAL:     cfg_q.focal     <= cfg_wdata_i[47:0];
        CFG_PRINCIPAL: cfg_q.principal <= cfg_wdata_i[47:0];
        CFG_IMAGE:     cfg_q.img       <= cfg_wdata_i[31:0];
        CFG_DIST:      cfg_q.dist_lim  <= cfg_wdata_i[47:0];
        default: ;
      endcase
    end
  end

  ptp_front #(
    .POINT_TAG_BITS(POINT_TAG_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (push),
    .in_item_i  (in_item_i),
    .in_ready_o (in_ready),
    .mid_push_o (mid_push),
    .mid_item_o (mid_wdata),
    .mid_full_i (mid_full)
  );

  ptp_fifo #(
    .Width($bits(mid_item_t)),
    .Depth(MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty)
  );

  ptp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_rdata),
    .mid_pop_o   (mid_pop),
    .out_push_o  (out_push),
    .out_item_o  (out_wdata),
    .out_full_i  (out_full)
  );

  ptp_fifo #(
    .Width($bits(out_item_t)),
    .Depth(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

  a_mid_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mid_push && mid_full))
    else $error("front pushed into a full queue");

  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_push && out_full))
    else $error("back pushed into a full result queue");

  a_miss_zero_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.hit) |-> (out_item_o.pixel_col == '0 &&
                                     out_item_o.pixel_row == '0))
    else $error("rejected item carries a pixel");

endmodule

`default_nettype wire
